// File: sv/mcw_pkg.sv
// Shared constants, codes and types for the minimum covering window core.
`timescale 1ns / 1ps
`default_nettype none

package mcw_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int TEXT_DEPTH    = 4096;
    localparam int PATTERN_MAX   = 255;

    localparam int SYM_W  = 8;
    localparam int ADDR_W = 12;
    localparam int POS_W  = 13;
    localparam int NEED_W = 8;
    localparam int SEEN_W = 13;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

    typedef struct packed {
        logic [NEED_W-1:0] needed;
        logic [SEEN_W-1:0] seen;
    } cnt_entry_t;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
        cnt_entry_t        entry;
    } cnt_wr_t;

endpackage

`default_nettype wire

// File: sv/mcw_count_mem.sv
// Per-symbol needed/seen count store with per-entry valid bits and registered read.
`timescale 1ns / 1ps
`default_nettype none

module mcw_count_mem
    import mcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       rd_en,
    input  logic [SYM_W-1:0] rd_addr,
    input  cnt_wr_t    wr,
    output cnt_entry_t rd_entry
);

    cnt_entry_t count_ram [ALPHABET_SIZE];
    cnt_entry_t rd_data_reg;
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            count_ram[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= count_ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // entries not written this job read as zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: sv/mcw_text_mem.sv
// Text byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mcw_text_mem
    import mcw_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SYM_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SYM_W-1:0]  rd_data
);

    logic [SYM_W-1:0] text_ram [TEXT_DEPTH];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= text_ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/minimum_covering_window_core.sv
// Top level: job sequencer for the minimum covering window search.
//
//  channel  | handshake                  | word fields
//  ---------+----------------------------+---------------------------------------------
//  item     | item_valid / item_stall    | command, symbol
//  result   | result_valid / result_stall| found, window_start, window_width, overflowed
//
// Pattern byte: count read, then write back. Command 3 and dropped bytes: handled in idle.
// Text byte: count read and update, plus when covered a text read then a count read
// per head step tried, and the best-window update; the head moves at most once per
// stored byte.
// End command: report state, held while a previous result word is still stalled.
// Reset and the end command clear the count store at once through its valid bits.
`timescale 1ns / 1ps
`default_nettype none

module minimum_covering_window_core
    import mcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [SYM_W-1:0]  symbol,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              found,
    output logic [ADDR_W-1:0] window_start,
    output logic [POS_W-1:0]  window_width,
    output logic              overflowed
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PAT_WR   = 3'd1;
    localparam logic [2:0] S_TXT_UPD  = 3'd2;
    localparam logic [2:0] S_HEAD_TXT = 3'd3;
    localparam logic [2:0] S_HEAD_CNT = 3'd4;
    localparam logic [2:0] S_BEST     = 3'd5;
    localparam logic [2:0] S_REPORT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0]  head_reg, head_next;
    logic [POS_W-1:0]  tail_reg, tail_next;
    logic [NEED_W-1:0] plen_reg, plen_next;
    logic [NEED_W-1:0] matched_reg, matched_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [POS_W-1:0]  best_width_reg, best_width_next;
    logic              best_valid_reg, best_valid_next;
    logic              ovf_reg, ovf_next;

    logic              res_valid_reg, res_valid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [POS_W-1:0]  width_reg, width_next;
    logic              res_ovf_reg, res_ovf_next;

    logic              cnt_clear;
    logic              cnt_rd_en;
    logic [SYM_W-1:0]  cnt_rd_addr;
    cnt_wr_t           cnt_wr;
    cnt_entry_t        cnt_entry;

    logic              txt_wr_en;
    logic              txt_rd_en;
    logic [ADDR_W-1:0] txt_rd_addr;
    logic [SYM_W-1:0]  txt_rd_data;

    logic              accept;
    logic [SEEN_W-1:0] need_ext;
    logic [SEEN_W-1:0] seen_inc;
    logic [NEED_W-1:0] matched_inc;
    logic [POS_W-1:0]  head_inc;
    logic [POS_W-1:0]  pos_ext;
    logic [POS_W-1:0]  cur_width;

    mcw_count_mem u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cnt_clear),
        .rd_en    (cnt_rd_en),
        .rd_addr  (cnt_rd_addr),
        .wr       (cnt_wr),
        .rd_entry (cnt_entry)
    );

    mcw_text_mem u_text (
        .clk     (clk),
        .wr_en   (txt_wr_en),
        .wr_addr (tail_reg[ADDR_W-1:0]),
        .wr_data (symbol),
        .rd_en   (txt_rd_en),
        .rd_addr (txt_rd_addr),
        .rd_data (txt_rd_data)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    assign need_ext    = SEEN_W'(cnt_entry.needed);
    assign seen_inc    = cnt_entry.seen + 1'b1;
    assign matched_inc = matched_reg + 1'b1;
    assign head_inc    = head_reg + 1'b1;
    assign pos_ext     = POS_W'(pos_reg);
    assign cur_width   = pos_ext - head_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        pos_next        = pos_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        plen_next       = plen_reg;
        matched_next    = matched_reg;
        best_start_next = best_start_reg;
        best_width_next = best_width_reg;
        best_valid_next = best_valid_reg;
        ovf_next        = ovf_reg;

        res_valid_next  = res_valid_reg && result_stall;
        found_next      = found_reg;
        start_next      = start_reg;
        width_next      = width_reg;
        res_ovf_next    = res_ovf_reg;

        cnt_clear   = 1'b0;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = symbol;
        cnt_wr      = '0;
        txt_wr_en   = 1'b0;
        txt_rd_en   = 1'b0;
        txt_rd_addr = head_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next = symbol;
                    case (command)
                        CMD_PATTERN:
                        begin
                            if (tail_reg == '0)
                            begin
                                if (plen_reg >= NEED_W'(PATTERN_MAX))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    cnt_rd_en  = 1'b1;
                                    state_next = S_PAT_WR;
                                end
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (tail_reg >= POS_W'(TEXT_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                txt_wr_en  = 1'b1;
                                pos_next   = tail_reg[ADDR_W-1:0];
                                tail_next  = tail_reg + 1'b1;
                                cnt_rd_en  = 1'b1;
                                state_next = S_TXT_UPD;
                            end
                        end
                        CMD_END:
                        begin
                            state_next = S_REPORT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PAT_WR:
            begin
                cnt_wr.en           = 1'b1;
                cnt_wr.addr         = sym_reg;
                cnt_wr.entry.needed = cnt_entry.needed + 1'b1;
                cnt_wr.entry.seen   = cnt_entry.seen;
                plen_next           = plen_reg + 1'b1;
                state_next          = S_IDLE;
            end

            S_TXT_UPD:
            begin
                state_next = S_IDLE;
                if (cnt_entry.needed != '0)
                begin
                    cnt_wr.en           = 1'b1;
                    cnt_wr.addr         = sym_reg;
                    cnt_wr.entry.needed = cnt_entry.needed;
                    cnt_wr.entry.seen   = seen_inc;
                    if (seen_inc <= need_ext)
                    begin
                        matched_next = matched_inc;
                    end
                end
                if (plen_reg != '0 && matched_next == plen_reg)
                begin
                    if (head_reg < pos_ext)
                    begin
                        txt_rd_en  = 1'b1;
                        state_next = S_HEAD_TXT;
                    end
                    else
                    begin
                        state_next = S_BEST;
                    end
                end
            end

            S_HEAD_TXT:
            begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = txt_rd_data;
                sym_next    = txt_rd_data;
                state_next  = S_HEAD_CNT;
            end

            S_HEAD_CNT:
            begin
                if (cnt_entry.needed != '0 && cnt_entry.seen <= need_ext)
                begin
                    state_next = S_BEST;
                end
                else
                begin
                    if (cnt_entry.needed != '0)
                    begin
                        cnt_wr.en           = 1'b1;
                        cnt_wr.addr         = sym_reg;
                        cnt_wr.entry.needed = cnt_entry.needed;
                        cnt_wr.entry.seen   = cnt_entry.seen - 1'b1;
                    end
                    head_next = head_inc;
                    if (head_inc < pos_ext)
                    begin
                        txt_rd_en   = 1'b1;
                        txt_rd_addr = head_inc[ADDR_W-1:0];
                        state_next  = S_HEAD_TXT;
                    end
                    else
                    begin
                        state_next = S_BEST;
                    end
                end
            end

            S_BEST:
            begin
                if (!best_valid_reg || cur_width < best_width_reg)
                begin
                    best_valid_next = 1'b1;
                    best_width_next = cur_width;
                    best_start_next = head_reg[ADDR_W-1:0];
                end
                state_next = S_IDLE;
            end

            S_REPORT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next  = 1'b1;
                    found_next      = best_valid_reg;
                    start_next      = best_start_reg;
                    width_next      = best_width_reg;
                    res_ovf_next    = ovf_reg;
                    cnt_clear       = 1'b1;
                    head_next       = '0;
                    tail_next       = '0;
                    plen_next       = '0;
                    matched_next    = '0;
                    best_start_next = '0;
                    best_width_next = '0;
                    best_valid_next = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sym_reg        <= '0;
            pos_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            plen_reg       <= '0;
            matched_reg    <= '0;
            best_start_reg <= '0;
            best_width_reg <= '0;
            best_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            start_reg      <= '0;
            width_reg      <= '0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sym_reg        <= sym_next;
            pos_reg        <= pos_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            plen_reg       <= plen_next;
            matched_reg    <= matched_next;
            best_start_reg <= best_start_next;
            best_width_reg <= best_width_next;
            best_valid_reg <= best_valid_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
            found_reg      <= found_next;
            start_reg      <= start_next;
            width_reg      <= width_next;
            res_ovf_reg    <= res_ovf_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign found        = found_reg;
    assign window_start = start_reg;
    assign window_width = width_reg;
    assign overflowed   = res_ovf_reg;

endmodule

`default_nettype wire

// File: sv/mcw_checker.sv
// Port-level checker for the minimum covering window core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcw_checker
    import mcw_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire logic [CMD_W-1:0]  command,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire logic              found,
    input wire logic [ADDR_W-1:0] window_start,
    input wire logic [POS_W-1:0]  window_width,
    input wire logic              overflowed
);

    logic [POS_W:0] win_end;
    assign win_end = (POS_W+1)'(window_start) + (POS_W+1)'(window_width);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(found)
            && $stable(window_start) && $stable(window_width) && $stable(overflowed))
        else $error("result word changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> window_width == '0 && window_start == '0)
        else $error("not-found result carries a window");

    a_found_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> window_width != '0
            && win_end <= (POS_W+1)'(TEXT_DEPTH))
        else $error("found window empty or beyond text store");

    a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == CMD_END && !result_valid
            |=> ##1 result_valid)
        else $error("end command gave no result word");

    a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == CMD_END |=> item_stall)
        else $error("item taken while report pending");

endmodule

bind minimum_covering_window_core mcw_checker u_mcw_checker (.*);

`default_nettype wire
